// ----- rtl/core/modbus_rtu_request_framer_defines.svh -----
// Assertion macros shared by the Modbus RTU request framer RTL.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define MRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define MRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mrf_pkg.sv -----
// Shared types, constants and the CRC step for the Modbus RTU request framer.
package mrf_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

  localparam logic [7:0] REG_STATUS    = 8'h02;
  localparam logic [7:0] REG_HANDSHAKE = 8'h0B;
  localparam logic [7:0] REG_CURRENT   = 8'h51;
  localparam logic [7:0] REG_VOLTAGE   = 8'h00;
  localparam logic [7:0] REG_OUTPUT    = 8'h09;
  localparam logic [7:0] REG_HIGH      = 8'h00;

  localparam logic [15:0] READ_COUNT       = 16'd2;
  localparam logic [7:0]  MULTI_BYTE_COUNT = 8'h04;

  localparam logic [3:0] LEN_SINGLE = 4'd8;
  localparam logic [3:0] LEN_MULTI  = 4'd13;

  typedef enum logic [2:0] {
    CMD_READ_STATUS = 3'd0,
    CMD_HANDSHAKE   = 3'd1,
    CMD_SET_CURRENT = 3'd2,
    CMD_SET_VOLTAGE = 3'd3,
    CMD_SET_BOTH    = 3'd4,
    CMD_SET_OUTPUT  = 3'd5
  } command_t;

  // One classified request, everything the byte sequencer needs.
  typedef struct packed {
    logic [7:0]  fn;
    logic [7:0]  reg_lo;
    logic [15:0] value;
    logic        multi;
    logic [15:0] voltage;
    logic [15:0] current;
  } frame_desc_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mrf_front.sv -----
// Command intake: classifies each command word and queues a frame descriptor for each defined one.
module mrf_front #(
  parameter int Depth = mrf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           command,
  input  logic [15:0]          current_centi,
  input  logic [15:0]          voltage_centi,
  input  logic                 output_on,
  output logic                 q_valid,
  input  logic                 q_pop,
  output mrf_pkg::frame_desc_t q_desc
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  mrf_pkg::frame_desc_t queue_mem [Depth];
  logic [CntW-1:0]      count;
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  mrf_pkg::frame_desc_t desc;
  logic                 cmd_ok;
  logic                 push;

  always_comb begin
    cmd_ok       = 1'b1;
    desc.voltage = voltage_centi;
    desc.current = current_centi;
    desc.multi   = 1'b0;
    desc.fn      = mrf_pkg::FN_WRITE_SINGLE;
    desc.reg_lo  = mrf_pkg::REG_VOLTAGE;
    desc.value   = voltage_centi;
    unique case (command)
      mrf_pkg::CMD_READ_STATUS: begin
        desc.fn     = mrf_pkg::FN_READ_HOLDING;
        desc.reg_lo = mrf_pkg::REG_STATUS;
        desc.value  = mrf_pkg::READ_COUNT;
      end
      mrf_pkg::CMD_HANDSHAKE: begin
        desc.fn     = mrf_pkg::FN_READ_HOLDING;
        desc.reg_lo = mrf_pkg::REG_HANDSHAKE;
        desc.value  = mrf_pkg::READ_COUNT;
      end
      mrf_pkg::CMD_SET_CURRENT: begin
        desc.reg_lo = mrf_pkg::REG_CURRENT;
        desc.value  = current_centi;
      end
      mrf_pkg::CMD_SET_VOLTAGE: begin
        desc.reg_lo = mrf_pkg::REG_VOLTAGE;
        desc.value  = voltage_centi;
      end
      mrf_pkg::CMD_SET_BOTH: begin
        desc.fn     = mrf_pkg::FN_WRITE_MULTI;
        desc.reg_lo = mrf_pkg::REG_VOLTAGE;
        desc.value  = mrf_pkg::READ_COUNT;
        desc.multi  = 1'b1;
      end
      mrf_pkg::CMD_SET_OUTPUT: begin
        desc.reg_lo = mrf_pkg::REG_OUTPUT;
        desc.value  = {15'd0, output_on};
      end
      default: begin
        // Undefined command codes are taken and dropped without a frame.
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == CntW'(Depth));
  assign push     = in_valid && !in_stall && cmd_ok;
  assign q_valid  = (count != '0);
  assign q_desc   = queue_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        queue_mem[wr_ptr] <= desc;
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/mrf_back.sv -----
// Byte sequencer: walks one descriptor out as frame bytes with a running CRC.
module mrf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           slave_addr,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  mrf_pkg::frame_desc_t q_desc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           frame_byte,
  output logic                 last_byte
);

  mrf_pkg::frame_desc_t desc;
  logic                 busy;
  logic [3:0]           idx;
  logic [15:0]          crc;
  logic [3:0]           frame_len;
  logic [7:0]           byte_sel;
  logic                 is_crc;
  logic                 is_last;
  logic                 load;

  assign frame_len = desc.multi ? mrf_pkg::LEN_MULTI : mrf_pkg::LEN_SINGLE;
  assign is_last   = (idx == frame_len - 4'd1);
  assign is_crc    = (idx == frame_len - 4'd2) || is_last;
  assign load      = busy && (!out_valid || !out_stall);
  assign q_pop     = q_valid && !busy;

  always_comb begin
    priority if (is_last) begin
      byte_sel = crc[15:8];
    end else if (is_crc) begin
      byte_sel = crc[7:0];
    end else begin
      unique case (idx)
        4'd0:    byte_sel = slave_addr;
        4'd1:    byte_sel = desc.fn;
        4'd2:    byte_sel = mrf_pkg::REG_HIGH;
        4'd3:    byte_sel = desc.reg_lo;
        4'd4:    byte_sel = desc.value[15:8];
        4'd5:    byte_sel = desc.value[7:0];
        4'd6:    byte_sel = mrf_pkg::MULTI_BYTE_COUNT;
        4'd7:    byte_sel = desc.voltage[15:8];
        4'd8:    byte_sel = desc.voltage[7:0];
        4'd9:    byte_sel = desc.current[15:8];
        4'd10:   byte_sel = desc.current[7:0];
        default: byte_sel = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        desc <= q_desc;
        idx  <= '0;
        crc  <= mrf_pkg::CRC_INIT;
      end else if (load) begin
        frame_byte <= byte_sel;
        last_byte  <= is_last;
        idx        <= idx + 4'd1;
        if (!is_crc) begin
          crc <= mrf_pkg::crc16_byte(crc, byte_sel);
        end
        if (is_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/core/modbus_rtu_request_framer.sv -----
// A frame's first byte passes the command queue, descriptor register and output register.
// The sequencer emits one byte per cycle while out_stall is low; frames are 8 bytes for
// single-register requests and 13 for set-both, and are sent one frame at a time.
// A two-word command queue lets intake run ahead while the byte sequencer is stalled.
// Reset empties the queue and output register and sets the slave address to 1.
`include "modbus_rtu_request_framer_defines.svh"

module modbus_rtu_request_framer #(
  parameter int QueueDepth = mrf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  slave_address,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [15:0] current_centi,
  input  logic [15:0] voltage_centi,
  input  logic        output_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);

  logic                 [7:0] slave_addr;
  logic                 q_valid;
  logic                 q_pop;
  mrf_pkg::frame_desc_t q_desc;
  logic                 cmd_taken;
  logic                 out_wait;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr <= mrf_pkg::SLAVE_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slave_addr <= slave_address;
    end
  end

  mrf_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .current_centi (current_centi),
    .voltage_centi (voltage_centi),
    .output_on     (output_on),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_desc        (q_desc)
  );

  mrf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .slave_addr (slave_addr),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_desc     (q_desc),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  assign cmd_taken = in_valid && !in_stall && (command <= mrf_pkg::CMD_SET_OUTPUT);
  assign out_wait  = out_valid && out_stall;

  `MRF_ASSERT_SAME(a_pop_needs_word, q_pop, q_valid, "sequencer popped an empty queue")
  `MRF_ASSERT_NEXT(a_cmd_queued, cmd_taken, q_valid, "accepted command did not reach the queue")
  `MRF_ASSERT_NEXT(a_out_held, out_wait, out_valid && $stable(frame_byte), "stalled word moved")

endmodule

// ----- dv/tb_modbus_rtu_request_framer.sv -----
// Self-checking testbench for the Modbus RTU request framer, with its frame predictor.
`timescale 1ns / 100ps

package mrf_tb_pkg;

  // Command codes outside the supported set; the framer drops them silently.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [7:0]  FUNC_READ       = 8'h03;
  localparam logic [7:0]  FUNC_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FUNC_WRITE_MANY = 8'h10;
  localparam logic [15:0] ADDR_STATUS     = 16'h0002;
  localparam logic [15:0] ADDR_HANDSHAKE  = 16'h000B;
  localparam logic [15:0] ADDR_CURRENT    = 16'h0051;
  localparam logic [15:0] ADDR_VOLTAGE    = 16'h0000;
  localparam logic [15:0] ADDR_OUTPUT     = 16'h0009;
  localparam logic [15:0] READ_WORDS      = 16'd2;
  localparam logic [7:0]  PAYLOAD_BYTES   = 8'h04;
  localparam logic [15:0] CRC_SEED        = 16'hFFFF;
  localparam logic [15:0] CRC_REV_POLY    = 16'hA001;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  class frame_scoreboard;
    frame_byte_t expected_q[$];
    logic [7:0]  address;
    int unsigned errors;
    int unsigned frames;
    int unsigned bytes_seen;
    int unsigned dropped;

    function new();
      address    = 8'h01;
      errors     = 0;
      frames     = 0;
      bytes_seen = 0;
      dropped    = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_REV_POLY) : {1'b0, c[15:1]};
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Builds the whole request frame for one accepted command word, or counts a spare code as dropped.
    function void note_command(logic [2:0] cmd, logic [15:0] cur, logic [15:0] vol,
                               logic on);
      logic [7:0]  body[$];
      logic [7:0]  func;
      logic [15:0] reg_addr;
      logic [15:0] value;
      logic [15:0] crc;
      case (cmd)
        mrf_pkg::CMD_READ_STATUS: begin
          func = FUNC_READ; reg_addr = ADDR_STATUS; value = READ_WORDS;
        end
        mrf_pkg::CMD_HANDSHAKE: begin
          func = FUNC_READ; reg_addr = ADDR_HANDSHAKE; value = READ_WORDS;
        end
        mrf_pkg::CMD_SET_CURRENT: begin
          func = FUNC_WRITE_ONE; reg_addr = ADDR_CURRENT; value = cur;
        end
        mrf_pkg::CMD_SET_VOLTAGE: begin
          func = FUNC_WRITE_ONE; reg_addr = ADDR_VOLTAGE; value = vol;
        end
        mrf_pkg::CMD_SET_BOTH: begin
          func = FUNC_WRITE_MANY; reg_addr = ADDR_VOLTAGE; value = READ_WORDS;
        end
        mrf_pkg::CMD_SET_OUTPUT: begin
          func = FUNC_WRITE_ONE; reg_addr = ADDR_OUTPUT; value = {15'd0, on};
        end
        default: begin
          dropped++;
          return;
        end
      endcase
      body.push_back(address);
      body.push_back(func);
      body.push_back(reg_addr[15:8]);
      body.push_back(reg_addr[7:0]);
      body.push_back(value[15:8]);
      body.push_back(value[7:0]);
      if (cmd == mrf_pkg::CMD_SET_BOTH) begin
        body.push_back(PAYLOAD_BYTES);
        body.push_back(vol[15:8]);
        body.push_back(vol[7:0]);
        body.push_back(cur[15:8]);
        body.push_back(cur[7:0]);
      end
      crc = CRC_SEED;
      foreach (body[i]) crc = crc_step(crc, body[i]);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      foreach (body[i]) expected_q.push_back('{body[i], i == body.size() - 1});
      frames++;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      bytes_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("byte %02h (last=%0b) arrived with nothing expected", data, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.data)
        report($sformatf("frame_byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("last_byte %0b, expected %0b (byte %02h)", last, want.last,
                         want.data));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d frame bytes never arrived", expected_q.size()));
    endtask
  endclass
endpackage

module tb_modbus_rtu_request_framer;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  slave_address;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [15:0] current_centi;
  logic [15:0] voltage_centi;
  logic        output_on;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  frame_byte;
  logic        last_byte;

  mrf_tb_pkg::frame_scoreboard sb;
  int unsigned     cycle_count;
  bit              hold_off_req;
  bit              rx_calm;
  bit              tx_calm;

  modbus_rtu_request_framer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .slave_address(slave_address),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .current_centi(current_centi),
    .voltage_centi(voltage_centi),
    .output_on    (output_on),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: checks every accepted byte and stalls at random or for a requested hold-off.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned roll;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_byte(frame_byte, last_byte);
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (stall_left == 0 && !rx_calm) begin
        roll = $urandom_range(0, 99);
        if (roll >= 94) stall_left = $urandom_range(10, 40);
        else if (roll >= 70) stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (tx_calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_setpoint();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'h0000;
    if (roll < 20) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offers one command word and holds it until taken; valid stays up when no gap follows.
  task automatic send_command(input logic [2:0] cmd, input logic [15:0] cur,
                              input logic [15:0] vol, input logic on);
    int unsigned gap;
    in_valid      <= 1'b1;
    command       <= cmd;
    current_centi <= cur;
    voltage_centi <= vol;
    output_on     <= on;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd, cur, vol, on);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned roll;
    logic [2:0]  cmd;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = mrf_tb_pkg::CMD_SPARE_6;
      else if (roll < 6) cmd = mrf_tb_pkg::CMD_SPARE_7;
      else cmd = 3'($urandom_range(0, 5));
      send_command(cmd, pick_setpoint(), pick_setpoint(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Drops valid, waits for every expected byte, then lets a dropped command drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] value);
    cfg_valid     <= 1'b1;
    slave_address <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.address = value;
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    slave_address = 8'h00;
    in_valid      = 1'b0;
    command       = mrf_pkg::CMD_READ_STATUS;
    current_centi = 16'h0000;
    voltage_centi = 16'h0000;
    output_on     = 1'b0;
    hold_off_req  = 1'b0;
    rx_calm       = 1'b0;
    tx_calm       = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset address: every command, setpoint extremes, spare codes.
    send_command(mrf_pkg::CMD_READ_STATUS, 16'h0000, 16'h0000, 1'b0);
    send_command(mrf_pkg::CMD_HANDSHAKE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(mrf_pkg::CMD_SET_CURRENT, 16'h0000, 16'hFFFF, 1'b1);
    send_command(mrf_pkg::CMD_SET_CURRENT, 16'hFFFF, 16'h0000, 1'b0);
    send_command(mrf_pkg::CMD_SET_CURRENT, 16'h1388, 16'h5A5A, 1'b0);
    send_command(mrf_pkg::CMD_SET_VOLTAGE, 16'hFFFF, 16'h0000, 1'b1);
    send_command(mrf_pkg::CMD_SET_VOLTAGE, 16'h0000, 16'hFFFF, 1'b0);
    send_command(mrf_pkg::CMD_SET_VOLTAGE, 16'hA5A5, 16'h0960, 1'b1);
    send_command(mrf_pkg::CMD_SET_BOTH, 16'h0000, 16'h0000, 1'b0);
    send_command(mrf_pkg::CMD_SET_BOTH, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(mrf_pkg::CMD_SET_BOTH, 16'hFEDC, 16'h1234, 1'b0);
    send_command(mrf_pkg::CMD_SET_OUTPUT, 16'hFFFF, 16'hFFFF, 1'b0);
    send_command(mrf_pkg::CMD_SET_OUTPUT, 16'h0000, 16'h0000, 1'b1);
    send_command(mrf_tb_pkg::CMD_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1);
    send_command(mrf_tb_pkg::CMD_SPARE_7, 16'hFFFF, 16'hFFFF, 1'b1);
    settle();

    write_address(8'h00);
    send_random(20);
    // The sender waits here until the framer has emitted everything it owes.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    send_random(20);
    settle();

    // Long receiver hold-off with back-to-back commands fills the queue and stalls intake.
    write_address(8'hFF);
    tx_calm      = 1'b1;
    hold_off_req = 1'b1;
    send_random(45);
    tx_calm = 1'b0;
    settle();

    write_address(8'($urandom_range(1, 254)));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    send_random(40);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    settle();

    write_address(8'($urandom_range(0, 255)));
    send_random(30);
    settle();

    sb.check_drained();
    $display("Checked %0d frames (%0d bytes) and %0d dropped spare commands,",
             sb.frames, sb.bytes_seen, sb.dropped);
    $display("over five slave addresses including 0 and 255, with stalls on both sides.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mrf_pkg.sv
rtl/core/mrf_front.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer.sv
dv/tb_modbus_rtu_request_framer.sv
